[hw/rtl/image_gradient_5tap_defines.svh]
// Assertion macros used by the checker module.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef IMAGE_GRADIENT_5TAP_DEFINES_SVH
`define IMAGE_GRADIENT_5TAP_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define IGR5_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("igr5 check failed");

// Next-cycle implication, disabled while reset is applied.
`define IGR5_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("igr5 check failed");

`endif

[hw/rtl/igr5_pkg.sv]
`default_nettype none
package igr5_pkg;

	// Field widths
	localparam int PIX_W     = 8;
	localparam int GRAD_W    = 13;
	localparam int ROW_W     = 13;
	localparam int DATA_W    = 13;
	localparam int CFG_IDX_W = 2;

	// Number of line slots held in one memory word
	localparam int LINES = 4;

	// Register limits and reset values
	localparam int WIDTH_MIN    = 5;
	localparam int HEIGHT_MIN   = 5;
	localparam int HEIGHT_MAX   = 4096;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [1:0] slot_t;
	typedef pix_t [LINES-1:0] line_word_t;
	typedef logic signed [GRAD_W-1:0] grad_t;

	// Position flags of one pixel, taken from the row and column counters
	typedef struct packed {
		logic  has_result;
		logic  gx_en;
		logic  gy_en;
		logic  frame_end;
		slot_t slot;
	} pos_info_t;

endpackage
`default_nettype wire

[hw/rtl/igr5_if.sv]
`default_nettype none
// Pixel request channel
interface igr5_in_if;
	import igr5_pkg::*;

	logic valid;
	logic ready;
	pix_t pixel;
	logic pad;

	modport source (output valid, output pixel, output pad, input ready);
	modport sink (input valid, input pixel, input pad, output ready);
endinterface

// Gradient result channel
interface igr5_out_if;
	import igr5_pkg::*;

	logic  valid;
	logic  ready;
	grad_t grad_x;
	grad_t grad_y;
	logic  frame_end;

	modport source (output valid, output grad_x, output grad_y, output frame_end, input ready);
	modport sink (input valid, input grad_x, input grad_y, input frame_end, output ready);
endinterface
`default_nettype wire

[hw/rtl/igr5_pos.sv]
`default_nettype none
// Frame geometry registers and raster position counters
module igr5_pos #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire  logic                            clk,
	input  wire  logic                            arst_n,
	input  wire  logic                            cfg_we,
	input  wire  logic [igr5_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  logic [igr5_pkg::DATA_W-1:0]     cfg_data,
	input  wire  logic                            acc,
	output logic [$clog2(MAX_WIDTH)-1:0]          addr_a,
	output logic [$clog2(MAX_WIDTH)-1:0]          addr_b,
	output igr5_pkg::pos_info_t                   info
);
	import igr5_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int XW = WW + 1;
	localparam int RST_WIDTH = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

	logic [WW-1:0]    width_q;
	logic [ROW_W-1:0] height_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;
	logic             col_last;
	logic             row_last;

	// Detect the end of a row and of the padded frame
	assign col_last = (XW'(col_q) + XW'(1)) == XW'(width_q);
	assign row_last = row_q == (height_q + ROW_W'(1));

	// Configuration and counters; a register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(RST_WIDTH);
			height_q <= ROW_W'(RESET_HEIGHT);
			row_q    <= '0;
			col_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH: begin
					if (int'(cfg_data) > MAX_WIDTH) begin
						width_q <= WW'(MAX_WIDTH);
					end else if (int'(cfg_data) < WIDTH_MIN) begin
						width_q <= WW'(WIDTH_MIN);
					end else begin
						width_q <= WW'(cfg_data);
					end
					row_q <= '0;
					col_q <= '0;
				end
				CFG_IMAGE_HEIGHT: begin
					if (int'(cfg_data) > HEIGHT_MAX) begin
						height_q <= ROW_W'(HEIGHT_MAX);
					end else if (int'(cfg_data) < HEIGHT_MIN) begin
						height_q <= ROW_W'(HEIGHT_MIN);
					end else begin
						height_q <= cfg_data;
					end
					row_q <= '0;
					col_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (acc) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Address the current column and the column two ahead
	assign addr_a = col_q;
	assign addr_b = col_q + CW'(2);

	// Flag edges and the frame's last pixel
	always_comb begin
		info.has_result = row_q >= ROW_W'(2);
		info.gx_en      = (col_q >= CW'(2)) && ((XW'(col_q) + XW'(2)) < XW'(width_q));
		info.gy_en      = (row_q >= ROW_W'(4)) && (row_q < height_q);
		info.frame_end  = row_last && col_last;
		info.slot       = row_q[1:0];
	end

endmodule
`default_nettype wire

[hw/rtl/igr5_line_mem.sv]
`default_nettype none
// Line store: one word per column, one byte slot per buffered row.
// Byte write at one address, two full-word reads with registered data.
module igr5_line_mem #(
	parameter int DEPTH = 1024
) (
	input  wire  logic                      clk,
	input  wire  logic                      we,
	input  wire  logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire  igr5_pkg::slot_t           wslot,
	input  wire  igr5_pkg::pix_t            wdata,
	input  wire  logic                      re,
	input  wire  logic [$clog2(DEPTH)-1:0]  addr_a,
	input  wire  logic [$clog2(DEPTH)-1:0]  addr_b,
	output igr5_pkg::line_word_t            rd_a,
	output igr5_pkg::line_word_t            rd_b
);
	import igr5_pkg::*;

	line_word_t mem [DEPTH];

	// Write one slot; reads return the contents from before this edge
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][wslot] <= wdata;
		end
		if (re) begin
			rd_a <= mem[addr_a];
			rd_b <= mem[addr_b];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/igr5_grad.sv]
`default_nettype none
// Kernel arithmetic: horizontal window history, both derivatives,
// and the output register.
module igr5_grad (
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	input  wire  logic                  acc,
	input  wire  igr5_pkg::pix_t        pix,
	input  wire  igr5_pkg::pos_info_t   info,
	input  wire  igr5_pkg::line_word_t  rd_a,
	input  wire  igr5_pkg::line_word_t  rd_b,
	input  wire  logic                  out_ready,
	output logic                        in_ready,
	output logic                        out_valid,
	output igr5_pkg::grad_t             grad_x,
	output igr5_pkg::grad_t             grad_y,
	output logic                        frame_end
);
	import igr5_pkg::*;

	logic      valid_s1;
	pos_info_t info_s1;
	pix_t      pix_s1;
	pix_t      a2_q;
	pix_t      a1_q;
	pix_t      b1_q;
	logic      out_valid_s2;
	grad_t     grad_x_s2;
	grad_t     grad_y_s2;
	logic      frame_end_s2;
	logic      out_free;
	logic      s1_drain;
	pix_t      a_cur;
	pix_t      b_cur;
	grad_t     gx;
	grad_t     gy;

	// Stage 1 drains unless it holds a result the output cannot take
	assign out_free = !out_valid_s2 || out_ready;
	assign s1_drain = valid_s1 && (!info_s1.has_result || out_free);
	assign in_ready = !valid_s1 || s1_drain;

	// Hold the position flags and the pixel while the memory read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			info_s1 <= info;
			pix_s1  <= pix;
		end
	end

	// Select the center row from both reads
	assign a_cur = rd_a[info_s1.slot - 2'd2];
	assign b_cur = rd_b[info_s1.slot - 2'd2];

	// Advance the window: columns c-2, c-1 from port A, c+1 from port B
	always_ff @(posedge clk) begin
		if (s1_drain) begin
			a2_q <= a1_q;
			a1_q <= a_cur;
			b1_q <= b_cur;
		end
	end

	// Apply the kernel 1, -8, 0, 8, -1 in both directions
	always_comb begin
		gx = signed'(GRAD_W'(a2_q)) - (signed'(GRAD_W'(a1_q)) <<< 3)
			+ (signed'(GRAD_W'(b1_q)) <<< 3) - signed'(GRAD_W'(b_cur));
		gy = signed'(GRAD_W'(rd_a[info_s1.slot]))
			- (signed'(GRAD_W'(rd_a[info_s1.slot + 2'd1])) <<< 3)
			+ (signed'(GRAD_W'(rd_a[info_s1.slot - 2'd1])) <<< 3)
			- signed'(GRAD_W'(pix_s1));
	end

	// Output register; zero the derivative near the edges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= s1_drain && info_s1.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_drain && info_s1.has_result) begin
			grad_x_s2    <= info_s1.gx_en ? gx : '0;
			grad_y_s2    <= info_s1.gy_en ? gy : '0;
			frame_end_s2 <= info_s1.frame_end;
		end
	end

	assign out_valid = out_valid_s2;
	assign grad_x    = grad_x_s2;
	assign grad_y    = grad_y_s2;
	assign frame_end = frame_end_s2;

endmodule
`default_nettype wire

[hw/rtl/image_gradient_5tap.sv]
`default_nettype none
// Channel   Dir  Payload                           Handshake
// pix_in    in   pixel[7:0], pad                   valid/ready
// grad_out  out  grad_x[12:0], grad_y[12:0], frame_end  valid/ready
// cfg       in   cfg_index[1:0], cfg_data[12:0]    cfg_we, no wait
//
// One pixel per cycle sustained while grad_out is not stalled; a result is registered
// in stage 1 alongside the line store read, then in the output register.
// Reset clears the counters and control; the line store has no reset, and data
// read from entries the current frame has not yet written is always discarded.
// A stalled result stops the pipe only once stage 1 also holds a result;
// pixels of the first two rows pass without producing one.
module image_gradient_5tap #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire  logic                            clk,
	input  wire  logic                            arst_n,
	input  wire  logic                            cfg_we,
	input  wire  logic [igr5_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  logic [igr5_pkg::DATA_W-1:0]     cfg_data,
	igr5_in_if.sink                               pix_in,
	igr5_out_if.source                            grad_out
);
	import igr5_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic       acc;
	logic       in_ready;
	logic [CW-1:0] addr_a;
	logic [CW-1:0] addr_b;
	pos_info_t  info;
	line_word_t rd_a;
	line_word_t rd_b;

	// Accept a request when stage 1 can take it
	assign acc          = pix_in.valid && in_ready;
	assign pix_in.ready = in_ready;

	igr5_pos #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.addr_a    (addr_a),
		.addr_b    (addr_b),
		.info      (info)
	);

	igr5_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_line_mem (
		.clk    (clk),
		.we     (acc),
		.waddr  (addr_a),
		.wslot  (info.slot),
		.wdata  (pix_in.pixel),
		.re     (acc),
		.addr_a (addr_a),
		.addr_b (addr_b),
		.rd_a   (rd_a),
		.rd_b   (rd_b)
	);

	igr5_grad u_grad (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.pix       (pix_in.pixel),
		.info      (info),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.out_ready (grad_out.ready),
		.in_ready  (in_ready),
		.out_valid (grad_out.valid),
		.grad_x    (grad_out.grad_x),
		.grad_y    (grad_out.grad_y),
		.frame_end (grad_out.frame_end)
	);

endmodule
`default_nettype wire

[hw/rtl/igr5_check.sv]
`default_nettype none
`include "image_gradient_5tap_defines.svh"
// Port-level checks on the gradient block
module igr5_check (
	input  wire  logic              clk,
	input  wire  logic              arst_n,
	input  wire  logic              in_valid,
	input  wire  logic              in_ready,
	input  wire  logic              out_valid,
	input  wire  logic              out_ready,
	input  wire  igr5_pkg::grad_t   grad_x,
	input  wire  igr5_pkg::grad_t   grad_y,
	input  wire  logic              frame_end
);
	import igr5_pkg::*;

	// Hold a stalled result
	`IGR5_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// Keep the horizontal derivative within the kernel's range
	`IGR5_ASSERT_IMPLY(a_gx_range, out_valid, (grad_x >= -13'sd2295) && (grad_x <= 13'sd2295))

	// Last pixel sits on an edge column and an edge row: both derivatives zero
	`IGR5_ASSERT_IMPLY(a_end_zero, out_valid && frame_end, (grad_x == '0) && (grad_y == '0))

	// Refuse a request only behind a stalled result
	`IGR5_ASSERT_IMPLY(a_ready_stall, in_valid && !in_ready, out_valid && !out_ready)

endmodule

bind image_gradient_5tap igr5_check u_igr5_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (grad_out.valid),
	.out_ready (grad_out.ready),
	.grad_x    (grad_out.grad_x),
	.grad_y    (grad_out.grad_y),
	.frame_end (grad_out.frame_end)
);
`default_nettype wire
